// ----- design/gtg_pkg.sv -----
// Shared types, constants and the arctangent table for the go-to-goal
// proportional controller. No dependencies; used by every design file.
package gtg_pkg;

  // Default number of CORDIC cells in the chain
  localparam int unsigned CordicStepsDef = 16;
  // Table length constant; the table itself has entries up to step index 16
  localparam int unsigned AtanTableLen = 24;

  // Field widths
  localparam int unsigned PosW   = 16;  // Q5.11 positions
  localparam int unsigned AngW   = 16;  // Q3.13 angles
  localparam int unsigned ThrW   = 15;
  localparam int unsigned GainW  = 4;
  localparam int unsigned LinW   = 14;
  localparam int unsigned DistW  = 17;
  localparam int unsigned DiffW  = PosW + 1;  // goal minus pose
  localparam int unsigned PreShift = 8;       // scale before the CORDIC
  localparam int unsigned XW     = 28;        // CORDIC x/y datapath
  localparam int unsigned ZW     = 20;        // angle accumulator, 16 fraction bits
  localparam int unsigned ProdW  = XW + 17;   // x times 1/K
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  // Constants
  localparam logic signed [ZW-1:0]   HalfPiQ16 = 20'sd102944;
  localparam logic signed [ZW-1:0]   PiQ13Z    = 20'sd25736;
  localparam logic signed [17:0]     PiQ13     = 18'sd25736;
  localparam logic signed [17:0]     TwoPiQ13  = 18'sd51472;
  localparam logic signed [17:0]     InvKQ16   = 18'sd39797;
  localparam logic signed [ProdW-1:0] DistRound = ProdW'(64'sd8388608);  // 2^23
  localparam logic [20:0]            LinMax    = 21'd10240;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgGoalX    = 3'd0,
    CfgGoalY    = 3'd1,
    CfgThresh   = 3'd2,
    CfgDistGain = 3'd3,
    CfgHeadGain = 3'd4
  } cfg_idx_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic signed [PosW-1:0] goal_x;
    logic signed [PosW-1:0] goal_y;
    logic [ThrW-1:0]        threshold;
    logic [GainW-1:0]       dist_gain;
    logic [GainW-1:0]       head_gain;
  } cfg_t;

  // Payload handed from cell to cell
  typedef struct packed {
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
    logic signed [AngW-1:0] heading;
  } cordic_t;

  // round(atan(2^-i) * 2^16); zero from step 17 on
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:  r = 20'sd51472;
      1:  r = 20'sd30386;
      2:  r = 20'sd16055;
      3:  r = 20'sd8150;
      4:  r = 20'sd4091;
      5:  r = 20'sd2047;
      6:  r = 20'sd1024;
      7:  r = 20'sd512;
      8:  r = 20'sd256;
      9:  r = 20'sd128;
      10: r = 20'sd64;
      11: r = 20'sd32;
      12: r = 20'sd16;
      13: r = 20'sd8;
      14: r = 20'sd4;
      15: r = 20'sd2;
      16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/gtg_pre.sv -----
// Entry stage: goal-minus-pose vector, prescale and quadrant pre-rotation.
// Depends on gtg_pkg.
module gtg_pre (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gtg_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [gtg_pkg::PosW-1:0] pose_x_i,
  input  logic signed [gtg_pkg::PosW-1:0] pose_y_i,
  input  logic signed [gtg_pkg::AngW-1:0] heading_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output gtg_pkg::cordic_t              data_o
);

  logic signed [gtg_pkg::DiffW-1:0] dx, dy;
  logic signed [gtg_pkg::XW-1:0]    xe, ye;
  gtg_pkg::cordic_t                 data_d, data_q;
  logic                             valid_q, load;

  // Exact 17-bit differences, scaled by 2^8
  assign dx = {cfg_i.goal_x[gtg_pkg::PosW-1], cfg_i.goal_x}
            - {pose_x_i[gtg_pkg::PosW-1], pose_x_i};
  assign dy = {cfg_i.goal_y[gtg_pkg::PosW-1], cfg_i.goal_y}
            - {pose_y_i[gtg_pkg::PosW-1], pose_y_i};
  assign xe = {{(gtg_pkg::XW - gtg_pkg::DiffW - gtg_pkg::PreShift){dx[gtg_pkg::DiffW-1]}},
               dx, {gtg_pkg::PreShift{1'b0}}};
  assign ye = {{(gtg_pkg::XW - gtg_pkg::DiffW - gtg_pkg::PreShift){dy[gtg_pkg::DiffW-1]}},
               dy, {gtg_pkg::PreShift{1'b0}}};

  // Left half plane: rotate by a quarter turn into the right half
  always_comb begin
    data_d.heading = heading_i;
    if (dx[gtg_pkg::DiffW-1]) begin
      if (!dy[gtg_pkg::DiffW-1]) begin
        data_d.x = ye;
        data_d.y = -xe;
        data_d.z = gtg_pkg::HalfPiQ16;
      end else begin
        data_d.x = -ye;
        data_d.y = xe;
        data_d.z = -gtg_pkg::HalfPiQ16;
      end
    end else begin
      data_d.x = xe;
      data_d.y = ye;
      data_d.z = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/gtg_cell.sv -----
// One vectoring CORDIC micro-rotation with its own pipeline register.
// Depends on gtg_pkg.
module gtg_cell #(
  parameter int unsigned StepIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  gtg_pkg::cordic_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output gtg_pkg::cordic_t data_o
);

  logic signed [gtg_pkg::XW-1:0] xs, ys;
  gtg_pkg::cordic_t              data_d, data_q;
  logic                          valid_q, load;

  // Arithmetic shifts round toward minus infinity
  assign xs = data_i.x >>> StepIdx;
  assign ys = data_i.y >>> StepIdx;

  // Rotate toward the x axis
  always_comb begin
    data_d.heading = data_i.heading;
    if (!data_i.y[gtg_pkg::XW-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + gtg_pkg::atan_q16(StepIdx);
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - gtg_pkg::atan_q16(StepIdx);
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/gtg_post.sv -----
// Back end: gain correction, arrival test, heading error wrap and the
// proportional outputs, in three registered stages. Depends on gtg_pkg.
module gtg_post (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gtg_pkg::cfg_t                   cfg_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  gtg_pkg::cordic_t                data_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [gtg_pkg::LinW-1:0]        lin_o,
  output logic signed [gtg_pkg::PosW-1:0] ang_o,
  output logic                            arrived_o
);

  // Stage 1: x times 1/K
  logic                              v1_q, r1;
  logic signed [gtg_pkg::ProdW-1:0]  prod_q, prod_d;
  logic signed [gtg_pkg::ZW-1:0]     z_q;
  logic signed [gtg_pkg::AngW-1:0]   head_q;
  // Stage 2: distance, bearing, wrapped error
  logic                              v2_q, r2;
  logic                              arr2_q, arr2_d;
  logic [gtg_pkg::DistW-1:0]         dist_q, dist_d;
  logic signed [gtg_pkg::AngW-1:0]   err_q, err_d;
  logic signed [gtg_pkg::ProdW-1:0]  psum;
  logic signed [gtg_pkg::ZW-1:0]     bear_full;
  logic signed [17:0]                bear, err0, err1, err2;
  // Stage 3: gains and limits
  logic                              v3_q, r3;
  logic [gtg_pkg::LinW-1:0]          lin_q, lin_d;
  logic signed [gtg_pkg::PosW-1:0]   ang_q, ang_d;
  logic                              arr3_q;
  logic [20:0]                       lin_prod;
  logic signed [20:0]                ang_prod, ang_sh;

  // Ready chain, bubbles collapse
  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  assign prod_d = gtg_pkg::ProdW'(data_i.x * gtg_pkg::InvKQ16);

  // Distance rounded to Q5.11, negative clamps to zero
  assign psum   = prod_q + gtg_pkg::DistRound;
  assign dist_d = psum[gtg_pkg::ProdW-1] ? '0 : psum[40:24];
  assign arr2_d = dist_d <= {2'b00, cfg_i.threshold};

  // Bearing in Q3.13, then error wrapped into [-pi, pi] twice
  assign bear_full = (z_q + gtg_pkg::ZW'(4)) >>> 3;
  always_comb begin
    if (bear_full > gtg_pkg::PiQ13Z) begin
      bear = gtg_pkg::PiQ13;
    end else if (bear_full < -gtg_pkg::PiQ13Z) begin
      bear = -gtg_pkg::PiQ13;
    end else begin
      bear = 18'(bear_full);
    end
    err0 = bear - 18'(head_q);
    if (err0 > gtg_pkg::PiQ13) begin
      err1 = err0 - gtg_pkg::TwoPiQ13;
    end else if (err0 < -gtg_pkg::PiQ13) begin
      err1 = err0 + gtg_pkg::TwoPiQ13;
    end else begin
      err1 = err0;
    end
    if (err1 > gtg_pkg::PiQ13) begin
      err2 = err1 - gtg_pkg::TwoPiQ13;
    end else if (err1 < -gtg_pkg::PiQ13) begin
      err2 = err1 + gtg_pkg::TwoPiQ13;
    end else begin
      err2 = err1;
    end
  end
  assign err_d = err2[gtg_pkg::AngW-1:0];

  // Proportional outputs with clamp and saturation
  assign lin_prod = 21'(cfg_i.dist_gain) * 21'(dist_q);
  assign ang_prod = $signed({1'b0, cfg_i.head_gain}) * err_q;
  assign ang_sh   = (ang_prod + 21'sd2) >>> 2;
  always_comb begin
    if (arr2_q) begin
      lin_d = '0;
      ang_d = '0;
    end else begin
      lin_d = (lin_prod > gtg_pkg::LinMax) ? gtg_pkg::LinMax[gtg_pkg::LinW-1:0]
                                           : lin_prod[gtg_pkg::LinW-1:0];
      if (ang_sh > 21'sd32767) begin
        ang_d = 16'sh7fff;
      end else if (ang_sh < -21'sd32768) begin
        ang_d = 16'sh8000;
      end else begin
        ang_d = ang_sh[gtg_pkg::PosW-1:0];
      end
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      prod_q <= prod_d;
      z_q    <= data_i.z;
      head_q <= data_i.heading;
    end
    if (r2 && v1_q) begin
      dist_q <= dist_d;
      err_q  <= err_d;
      arr2_q <= arr2_d;
    end
    if (r3 && v2_q) begin
      lin_q  <= lin_d;
      ang_q  <= ang_d;
      arr3_q <= arr2_q;
    end
  end

  assign valid_o   = v3_q;
  assign lin_o     = lin_q;
  assign ang_o     = ang_q;
  assign arrived_o = arr3_q;

endmodule

// ----- design/go_to_goal_p_controller.sv -----
// Go-to-goal proportional controller: pose in, speed and turn commands out.
// An input beat passes the entry stage, the chain of CORDIC cells and the output stages in turn.
// Throughput: one beat per cycle while m_axis_tready stays high; each stage holds one item and bubbles close up.
// The chain of CORDIC cells performs one micro-rotation per cell.
// Reset clears all valid flags and loads goal 0, threshold 0, both gains 5.
module go_to_goal_p_controller #(
  parameter int unsigned CORDIC_STEPS = gtg_pkg::CordicStepsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input pose stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gtg_pkg::InDataW-1:0]      s_axis_tdata,   // pose_x, pose_y, pose_heading
  // Output command stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gtg_pkg::OutDataW-1:0]     m_axis_tdata,   // forward speed, turn rate,
                                                           // arrived flag, zero pad
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [gtg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [gtg_pkg::CfgW-1:0]         cfg_data_i
);

  gtg_pkg::cfg_t                   cfg_q;
  logic                            cv [0:CORDIC_STEPS];
  logic                            cr [0:CORDIC_STEPS];
  gtg_pkg::cordic_t                cd [0:CORDIC_STEPS];
  logic [gtg_pkg::LinW-1:0]        lin;
  logic signed [gtg_pkg::PosW-1:0] ang;
  logic                            arrived;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_x    <= '0;
      cfg_q.goal_y    <= '0;
      cfg_q.threshold <= '0;
      cfg_q.dist_gain <= 4'd5;
      cfg_q.head_gain <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (gtg_pkg::cfg_idx_e'(cfg_idx_i))
        gtg_pkg::CfgGoalX:    cfg_q.goal_x    <= cfg_data_i;
        gtg_pkg::CfgGoalY:    cfg_q.goal_y    <= cfg_data_i;
        gtg_pkg::CfgThresh:   cfg_q.threshold <= cfg_data_i[gtg_pkg::ThrW-1:0];
        gtg_pkg::CfgDistGain: cfg_q.dist_gain <= cfg_data_i[gtg_pkg::GainW-1:0];
        gtg_pkg::CfgHeadGain: cfg_q.head_gain <= cfg_data_i[gtg_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // Entry stage
  gtg_pre u_pre (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .pose_x_i  (s_axis_tdata[15:0]),
    .pose_y_i  (s_axis_tdata[31:16]),
    .heading_i (s_axis_tdata[47:32]),
    .valid_o   (cv[0]),
    .ready_i   (cr[0]),
    .data_o    (cd[0])
  );

  // Chain of CORDIC cells
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    gtg_cell #(.StepIdx(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .ready_o (cr[k]),
      .data_i  (cd[k]),
      .valid_o (cv[k+1]),
      .ready_i (cr[k+1]),
      .data_o  (cd[k+1])
    );
  end

  // Output stages
  gtg_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (cv[CORDIC_STEPS]),
    .ready_o   (cr[CORDIC_STEPS]),
    .data_i    (cd[CORDIC_STEPS]),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .lin_o     (lin),
    .ang_o     (ang),
    .arrived_o (arrived)
  );

  assign m_axis_tdata = {1'b0, arrived, ang, lin};

`ifndef ASSERT_OFF
  // Arrival forces both commands to zero
  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && arrived |-> lin == '0 && ang == '0)
    else $error("arrived beat with nonzero command");

  // Forward speed never exceeds the clamp
  a_lin_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 21'(lin) <= gtg_pkg::LinMax)
    else $error("linear velocity above clamp");

  // Zero heading gain gives no turn
  a_zero_hgain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cfg_q.head_gain == '0 |-> ang == '0)
    else $error("turn command with zero heading gain");

  // An accepted beat lands in the entry stage
  a_entry_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> cv[0])
    else $error("accepted beat lost at entry stage");
`endif

endmodule
